>>> sv/rci_pkg.sv
// Shared constants, latencies and types of the ray / cylinder intersector.
// No dependencies; imported by the top level, rci_mul64, rci_sqrt and rci_div.
package rci_pkg;

	localparam int unsigned ZERO_TOLERANCE = 7;

	localparam logic [31:0] Y_NEG_INF = 32'h8000_0000;
	localparam logic [31:0] Y_POS_INF = 32'h7FFF_FFFF;

	typedef enum logic [1:0] {
		REG_MIN_Y  = 2'd0,
		REG_MAX_Y  = 2'd1,
		REG_CAPPED = 2'd2
	} cfg_reg_t;

	localparam int SQRT_BITS = 64;
	localparam int SQRT_LAT  = SQRT_BITS;
	localparam int MUL_LAT   = 2;
	localparam int DIV_NUM_W = 83;
	localparam int DIV_DEN_W = 64;
	localparam int DIV_QBITS = 33;
	localparam int DIV_LAT   = DIV_QBITS + 3;

	typedef struct packed {
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [31:0] oz;
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic signed [31:0] dz;
	} ray_t;

endpackage

>>> sv/ray_cylinder_intersect_unit.sv
// Ray against unit cylinder about Y, with optional end caps; top level.
// Depends on rci_pkg, rci_delay, rci_mul64, rci_sqrt and rci_div.
//
// Accepts one ray per clock cycle while in_ready is high; the pipeline stalls while
// a finished ray waits for the output register. Every ray produces one to four
// result transactions (side roots, then bottom and top caps, or a single no-hit
// marker); the output register hands them out one per cycle while out_ready is
// high. The depth of the pipeline comes mostly from the 64-stage square root and
// the 36-stage dividers. Configuration is taken whenever cfg_we is high and
// should change only while no ray is in flight.
module ray_cylinder_intersect_unit import rci_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] origin_z,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] dir_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] hit_t,
	output logic               hit_valid,
	output logic               last_hit,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_wdata
);

	localparam int LAT = 3 + MUL_LAT + 1 + SQRT_LAT + 1 + DIV_LAT + 3 + MUL_LAT + 1;

	typedef struct packed {
		ray_t               ray;
		logic signed [64:0] h;
		logic [63:0]        a;
		logic               side_ok;
	} pre_t;

	typedef struct packed {
		ray_t ray;
		logic side_ok;
		logic disc_neg;
		logic cap_ok;
	} div_side_t;

	typedef struct packed {
		logic signed [31:0] t0;
		logic signed [31:0] t1;
		logic signed [31:0] c0;
		logic signed [31:0] c1;
		logic               pass0;
		logic               pass1;
		logic               side_ok;
		logic               disc_neg;
		logic               cap_ok;
	} fin_t;

	// configuration
	logic [31:0] min_y_q, max_y_q;
	logic        capped_q;
	logic        lo_inf, hi_inf;
	logic signed [64:0] lo_sh, hi_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_y_q  <= Y_NEG_INF;
			max_y_q  <= Y_POS_INF;
			capped_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_MIN_Y:  min_y_q  <= cfg_wdata;
				REG_MAX_Y:  max_y_q  <= cfg_wdata;
				REG_CAPPED: capped_q <= cfg_wdata[0];
				default:    ;
			endcase
		end
	end

	assign lo_inf = (min_y_q == Y_NEG_INF);
	assign hi_inf = (max_y_q == Y_POS_INF);
	assign lo_sh  = $signed({{17{min_y_q[31]}}, min_y_q, 16'h0});
	assign hi_sh  = $signed({{17{max_y_q[31]}}, max_y_q, 16'h0});

	// pipeline control
	logic [LAT-1:0] vld_q;
	logic           en, load, take, done;
	logic           busy_q;
	logic [3:0]     mask_q;
	logic signed [31:0] hit_q [4];
	logic [1:0]     sel;

	assign take = busy_q && out_ready;
	assign done = take && last_hit;
	assign load = vld_q[LAT-1] && (!busy_q || done);
	assign en   = !vld_q[LAT-1] || load;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[LAT-2:0], in_valid};
	end

	// s1: products
	ray_t               ray_s1;
	logic signed [63:0] xdx_s1, zdz_s1;
	logic [63:0]        dxx_s1, dzz_s1, xx_s1, zz_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s1 <= '{origin_x, origin_y, origin_z, dir_x, dir_y, dir_z};
			xdx_s1 <= origin_x * dir_x;
			zdz_s1 <= origin_z * dir_z;
			dxx_s1 <= dir_x * dir_x;
			dzz_s1 <= dir_z * dir_z;
			xx_s1  <= origin_x * origin_x;
			zz_s1  <= origin_z * origin_z;
		end
	end

	// s2: sums
	ray_t               ray_s2;
	logic [63:0]        a_s2, ss_s2;
	logic signed [64:0] h_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s2 <= ray_s1;
			a_s2   <= dxx_s1 + dzz_s1;
			ss_s2  <= xx_s1 + zz_s1;
			h_s2   <= {xdx_s1[63], xdx_s1} + {zdz_s1[63], zdz_s1};
		end
	end

	// s3: magnitudes for the discriminant
	logic signed [64:0] hneg;
	pre_t               pre_s3;
	logic [63:0]        hm_s3, sm_s3;
	logic               ac_neg_s3;

	assign hneg = -h_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			pre_s3.ray     <= ray_s2;
			pre_s3.h       <= h_s2;
			pre_s3.a       <= a_s2;
			pre_s3.side_ok <= (a_s2 != '0) && (a_s2[63:16] >= 48'(ZERO_TOLERANCE));
			hm_s3          <= h_s2[64] ? hneg[63:0] : h_s2[63:0];
			ac_neg_s3      <= ss_s2 < 64'h1_0000_0000;
			sm_s3          <= (ss_s2 < 64'h1_0000_0000) ? 64'h1_0000_0000 - ss_s2
			                                            : ss_s2 - 64'h1_0000_0000;
		end
	end

	logic [127:0] hh_w, ac_w;
	logic         ac_neg_w;
	pre_t         pre_w;

	rci_mul64 u_mul_hh (.clk, .en, .a(hm_s3), .b(hm_s3), .p(hh_w));
	rci_mul64 u_mul_ac (.clk, .en, .a(pre_s3.a), .b(sm_s3), .p(ac_w));
	rci_delay #(.W(1), .N(MUL_LAT)) u_dly_acn (.clk, .en, .d(ac_neg_s3), .q(ac_neg_w));
	rci_delay #(.W($bits(pre_t)), .N(MUL_LAT + 1 + SQRT_LAT)) u_dly_pre (
		.clk, .en, .d(pre_s3), .q(pre_w)
	);

	// s4: discriminant
	logic [128:0] disc_s4;

	always_ff @(posedge clk) begin
		if (en)
			disc_s4 <= ac_neg_w ? {1'b0, hh_w} + {1'b0, ac_w} : {1'b0, hh_w} - {1'b0, ac_w};
	end

	logic [SQRT_BITS-1:0] root_w;
	logic                 disc_neg_w;

	rci_sqrt u_sqrt (.clk, .en, .rad(disc_s4[127:0]), .root(root_w));
	rci_delay #(.W(1), .N(SQRT_LAT)) u_dly_dn (.clk, .en, .d(disc_s4[128]), .q(disc_neg_w));

	// s5: numerators and divisors
	logic signed [DIV_NUM_W-1:0] hx, rx;
	logic signed [32:0]          bd0, bd1;
	logic [31:0]                 dymag;
	logic signed [DIV_NUM_W-1:0] num0_s5, num1_s5, cnum0_s5, cnum1_s5;
	logic [DIV_DEN_W-1:0]        aden_s5, cden_s5;
	div_side_t                   side_s5;

	assign hx    = DIV_NUM_W'(pre_w.h);
	assign rx    = $signed(DIV_NUM_W'(root_w));
	assign dymag = pre_w.ray.dy[31] ? ~pre_w.ray.dy + 32'd1 : pre_w.ray.dy;
	assign bd0   = pre_w.ray.dy[31]
		? {pre_w.ray.oy[31], pre_w.ray.oy} - $signed({min_y_q[31], min_y_q})
		: $signed({min_y_q[31], min_y_q}) - {pre_w.ray.oy[31], pre_w.ray.oy};
	assign bd1   = pre_w.ray.dy[31]
		? {pre_w.ray.oy[31], pre_w.ray.oy} - $signed({max_y_q[31], max_y_q})
		: $signed({max_y_q[31], max_y_q}) - {pre_w.ray.oy[31], pre_w.ray.oy};

	always_ff @(posedge clk) begin
		if (en) begin
			num0_s5          <= (-hx - rx) <<< 16;
			num1_s5          <= (-hx + rx) <<< 16;
			cnum0_s5         <= DIV_NUM_W'(bd0) <<< 16;
			cnum1_s5         <= DIV_NUM_W'(bd1) <<< 16;
			aden_s5          <= pre_w.a;
			cden_s5          <= DIV_DEN_W'(dymag);
			side_s5.ray      <= pre_w.ray;
			side_s5.side_ok  <= pre_w.side_ok;
			side_s5.disc_neg <= disc_neg_w;
			side_s5.cap_ok   <= capped_q && (dymag >= 32'(ZERO_TOLERANCE));
		end
	end

	logic signed [31:0] t0_w, t1_w, c0_w, c1_w;
	div_side_t          side_w;

	rci_div u_div_t0 (.clk, .en, .num(num0_s5),  .den(aden_s5), .quo(t0_w));
	rci_div u_div_t1 (.clk, .en, .num(num1_s5),  .den(aden_s5), .quo(t1_w));
	rci_div u_div_c0 (.clk, .en, .num(cnum0_s5), .den(cden_s5), .quo(c0_w));
	rci_div u_div_c1 (.clk, .en, .num(cnum1_s5), .den(cden_s5), .quo(c1_w));
	rci_delay #(.W($bits(div_side_t)), .N(DIV_LAT)) u_dly_side (
		.clk, .en, .d(side_s5), .q(side_w)
	);

	// s6: products with the hit distances
	fin_t               fin_s6, fin_s7, fin_s8, fin_w;
	logic signed [31:0] ox_s6, oy_s6, oz_s6;
	logic signed [63:0] tdy0_s6, tdy1_s6, cdx0_s6, cdz0_s6, cdx1_s6, cdz1_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			fin_s6.t0       <= t0_w;
			fin_s6.t1       <= t1_w;
			fin_s6.c0       <= c0_w;
			fin_s6.c1       <= c1_w;
			fin_s6.pass0    <= 1'b0;
			fin_s6.pass1    <= 1'b0;
			fin_s6.side_ok  <= side_w.side_ok;
			fin_s6.disc_neg <= side_w.disc_neg;
			fin_s6.cap_ok   <= side_w.cap_ok;
			ox_s6           <= side_w.ray.ox;
			oy_s6           <= side_w.ray.oy;
			oz_s6           <= side_w.ray.oz;
			tdy0_s6         <= t0_w * side_w.ray.dy;
			tdy1_s6         <= t1_w * side_w.ray.dy;
			cdx0_s6         <= c0_w * side_w.ray.dx;
			cdz0_s6         <= c0_w * side_w.ray.dz;
			cdx1_s6         <= c1_w * side_w.ray.dx;
			cdz1_s6         <= c1_w * side_w.ray.dz;
		end
	end

	// s7: hit point coordinates
	logic signed [64:0] oy_ext, yh0_s7, yh1_s7;
	logic signed [63:0] ox_ext, oz_ext, xh0_s7, zh0_s7, xh1_s7, zh1_s7;

	assign oy_ext = $signed({{17{oy_s6[31]}}, oy_s6, 16'h0});
	assign ox_ext = $signed({{16{ox_s6[31]}}, ox_s6, 16'h0});
	assign oz_ext = $signed({{16{oz_s6[31]}}, oz_s6, 16'h0});

	always_ff @(posedge clk) begin
		if (en) begin
			fin_s7 <= fin_s6;
			yh0_s7 <= oy_ext + {tdy0_s6[63], tdy0_s6};
			yh1_s7 <= oy_ext + {tdy1_s6[63], tdy1_s6};
			xh0_s7 <= ox_ext + cdx0_s6;
			zh0_s7 <= oz_ext + cdz0_s6;
			xh1_s7 <= ox_ext + cdx1_s6;
			zh1_s7 <= oz_ext + cdz1_s6;
		end
	end

	// s8: bound tests and magnitudes
	logic [63:0] mx0_s8, mz0_s8, mx1_s8, mz1_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			fin_s8.t0       <= fin_s7.t0;
			fin_s8.t1       <= fin_s7.t1;
			fin_s8.c0       <= fin_s7.c0;
			fin_s8.c1       <= fin_s7.c1;
			fin_s8.pass0    <= (lo_inf || yh0_s7 > lo_sh) && (hi_inf || yh0_s7 < hi_sh);
			fin_s8.pass1    <= (lo_inf || yh1_s7 > lo_sh) && (hi_inf || yh1_s7 < hi_sh);
			fin_s8.side_ok  <= fin_s7.side_ok;
			fin_s8.disc_neg <= fin_s7.disc_neg;
			fin_s8.cap_ok   <= fin_s7.cap_ok;
			mx0_s8          <= xh0_s7[63] ? 64'(-xh0_s7) : xh0_s7;
			mz0_s8          <= zh0_s7[63] ? 64'(-zh0_s7) : zh0_s7;
			mx1_s8          <= xh1_s7[63] ? 64'(-xh1_s7) : xh1_s7;
			mz1_s8          <= zh1_s7[63] ? 64'(-zh1_s7) : zh1_s7;
		end
	end

	logic [127:0] sqx0_w, sqz0_w, sqx1_w, sqz1_w;

	rci_mul64 u_mul_x0 (.clk, .en, .a(mx0_s8), .b(mx0_s8), .p(sqx0_w));
	rci_mul64 u_mul_z0 (.clk, .en, .a(mz0_s8), .b(mz0_s8), .p(sqz0_w));
	rci_mul64 u_mul_x1 (.clk, .en, .a(mx1_s8), .b(mx1_s8), .p(sqx1_w));
	rci_mul64 u_mul_z1 (.clk, .en, .a(mz1_s8), .b(mz1_s8), .p(sqz1_w));
	rci_delay #(.W($bits(fin_t)), .N(MUL_LAT)) u_dly_fin (.clk, .en, .d(fin_s8), .q(fin_w));

	// s9: disc tests and hit mask
	logic [127:0]       sq0, sq1;
	logic               in0, in1, kill;
	logic [3:0]         mask_s9;
	logic signed [31:0] hits_s9 [4];

	assign sq0  = sqx0_w + sqz0_w;
	assign sq1  = sqx1_w + sqz1_w;
	assign in0  = sq0 <= 128'h1_0000_0000_0000_0000;
	assign in1  = sq1 <= 128'h1_0000_0000_0000_0000;
	assign kill = fin_w.side_ok && fin_w.disc_neg;

	always_ff @(posedge clk) begin
		if (en) begin
			mask_s9[0] <= fin_w.side_ok && !fin_w.disc_neg && fin_w.pass0;
			mask_s9[1] <= fin_w.side_ok && !fin_w.disc_neg && fin_w.pass1;
			mask_s9[2] <= !kill && fin_w.cap_ok && !lo_inf && in0;
			mask_s9[3] <= !kill && fin_w.cap_ok && !hi_inf && in1;
			hits_s9[0] <= fin_w.t0;
			hits_s9[1] <= fin_w.t1;
			hits_s9[2] <= fin_w.c0;
			hits_s9[3] <= fin_w.c1;
		end
	end

	// output register: hand out the hits of one ray in order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mask_q <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			mask_q <= mask_s9;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (take) begin
			mask_q <= mask_q & (mask_q - 4'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			hit_q <= hits_s9;
	end

	always_comb begin
		if (mask_q[0])
			sel = 2'd0;
		else if (mask_q[1])
			sel = 2'd1;
		else if (mask_q[2])
			sel = 2'd2;
		else
			sel = 2'd3;
	end

	assign out_valid = busy_q;
	assign hit_valid = (mask_q != '0);
	assign hit_t     = hit_valid ? hit_q[sel] : 32'sd0;
	assign last_hit  = ((mask_q & (mask_q - 4'd1)) == 4'd0);

endmodule

>>> sv/rci_delay.sv
// Enabled delay line for sideband data travelling beside the arithmetic units.
// Depends on nothing but its parameters.
module rci_delay #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] tap_q [N];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= d;
			for (int i = 1; i < N; i++) begin
				tap_q[i] <= tap_q[i-1];
			end
		end
	end

	assign q = tap_q[N-1];

endmodule

>>> sv/rci_mul64.sv
// Two-stage unsigned 64 x 64 multiplier built from four 32 x 32 partial products.
// Depends on rci_pkg for nothing but house conventions.
module rci_mul64 import rci_pkg::*; (
	input  logic         clk,
	input  logic         en,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic [127:0] p
);

	logic [63:0]  ll_s1, lh_s1, hl_s1, hh_s1;
	logic [127:0] p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= a[31:0] * b[31:0];
			lh_s1 <= a[31:0] * b[63:32];
			hl_s1 <= a[63:32] * b[31:0];
			hh_s1 <= a[63:32] * b[63:32];
			p_s2  <= {hh_s1, ll_s1} + {32'b0, lh_s1, 32'b0} + {32'b0, hl_s1, 32'b0};
		end
	end

	assign p = p_s2;

endmodule

>>> sv/rci_sqrt.sv
// Pipelined integer square root, one result bit per stage (floor of the root).
// Depends on rci_pkg for SQRT_BITS.
module rci_sqrt import rci_pkg::*; (
	input  logic                   clk,
	input  logic                   en,
	input  logic [2*SQRT_BITS-1:0] rad,
	output logic [SQRT_BITS-1:0]   root
);

	localparam int N  = SQRT_BITS;
	localparam int RW = N + 2;

	logic [RW-1:0]  rem_s  [N-1];
	logic [2*N-1:0] rad_s  [N-1];
	logic [N-1:0]   root_s [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [RW-1:0]  rem_in;
		logic [N-1:0]   root_in;
		logic [2*N-1:0] rad_in;
		logic [RW+1:0]  cur, trial, diff;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rad;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign rad_in  = rad_s[k-1];
		end

		assign cur   = {rem_in, rad_in[2*N-1-2*k -: 2]};
		assign trial = {{(RW-N){1'b0}}, root_in, 2'b01};
		assign diff  = cur - trial;

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[k] <= {root_in[N-2:0], (cur >= trial)};
			end
		end

		if (k < N - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= (cur >= trial) ? diff[RW-1:0] : cur[RW-1:0];
					rad_s[k] <= rad_in;
				end
			end
		end
	end

	assign root = root_s[N-1];

endmodule

>>> sv/rci_div.sv
// Pipelined signed floor division with saturation to the 32-bit signed range.
// Depends on rci_pkg for DIV_NUM_W, DIV_DEN_W and DIV_QBITS.
module rci_div import rci_pkg::*; (
	input  logic                        clk,
	input  logic                        en,
	input  logic signed [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0]        den,
	output logic signed [31:0]          quo
);

	localparam int MW = DIV_NUM_W - 1;
	localparam int QB = DIV_QBITS;
	localparam int HW = MW - QB;
	localparam int DW = DIV_DEN_W;

	logic signed [DIV_NUM_W-1:0] nneg;
	logic                        neg_s1;
	logic [MW-1:0]               mag_s1;
	logic [DW-1:0]               den_s1;

	logic          neg_s2, over_s2;
	logic [QB-1:0] low_s2;
	logic [DW-1:0] den_s2, rem_s2;

	logic [DW-1:0] rem_s  [QB];
	logic [QB-1:0] q_s    [QB];
	logic          neg_s  [QB];
	logic          over_s [QB];
	logic [DW-1:0] den_s  [QB-1];
	logic [QB-1:0] low_s  [QB-1];

	logic [QB:0]        qq;
	logic signed [31:0] quo_q;

	assign nneg = -num;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= num[MW];
			mag_s1  <= num[MW] ? nneg[MW-1:0] : num[MW-1:0];
			den_s1  <= den;
			neg_s2  <= neg_s1;
			over_s2 <= {{(DW-HW){1'b0}}, mag_s1[MW-1:QB]} >= den_s1;
			rem_s2  <= {{(DW-HW){1'b0}}, mag_s1[MW-1:QB]};
			low_s2  <= mag_s1[QB-1:0];
			den_s2  <= den_s1;
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [DW-1:0] rem_in, den_in;
		logic [QB-1:0] q_in, low_in;
		logic          neg_in, over_in;
		logic [DW:0]   cur, dd, diff;

		if (k == 0) begin : g_first
			assign rem_in  = rem_s2;
			assign den_in  = den_s2;
			assign q_in    = '0;
			assign low_in  = low_s2;
			assign neg_in  = neg_s2;
			assign over_in = over_s2;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign den_in  = den_s[k-1];
			assign q_in    = q_s[k-1];
			assign low_in  = low_s[k-1];
			assign neg_in  = neg_s[k-1];
			assign over_in = over_s[k-1];
		end

		assign cur  = {rem_in, low_in[QB-1-k]};
		assign dd   = {1'b0, den_in};
		assign diff = cur - dd;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= (cur >= dd) ? diff[DW-1:0] : cur[DW-1:0];
				q_s[k]    <= {q_in[QB-2:0], (cur >= dd)};
				neg_s[k]  <= neg_in;
				over_s[k] <= over_in;
			end
		end

		if (k < QB - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					den_s[k] <= den_in;
					low_s[k] <= low_in;
				end
			end
		end
	end

	assign qq = {1'b0, q_s[QB-1]} + {{QB{1'b0}}, (rem_s[QB-1] != '0)};

	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_s[QB-1]) begin
				if (over_s[QB-1] || qq > (QB+1)'(33'h0_8000_0000))
					quo_q <= 32'sh8000_0000;
				else
					quo_q <= ~qq[31:0] + 32'd1;
			end else begin
				if (over_s[QB-1] || q_s[QB-1] > QB'(33'h0_7FFF_FFFF))
					quo_q <= 32'sh7FFF_FFFF;
				else
					quo_q <= q_s[QB-1][31:0];
			end
		end
	end

	assign quo = quo_q;

endmodule

>>> sv/rci_checker.sv
// Port-level checks on the intersector's result stream, bound to the top level.
// Depends on ray_cylinder_intersect_unit's ports only.
module rci_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] hit_t,
	input logic               hit_valid,
	input logic               last_hit
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit_t) && $stable(hit_valid)
			&& $stable(last_hit))
		else $error("result changed while stalled");

	a_nohit_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit_valid |-> last_hit && hit_t == 32'sd0)
		else $error("no-hit marker not a lone zero result");

	a_inner_is_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_hit |-> hit_valid)
		else $error("non-final result without a hit");

	a_ray_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_hit |=> out_valid)
		else $error("results of one ray not contiguous");

endmodule

bind ray_cylinder_intersect_unit rci_checker u_rci_checker (.*);
